[rtl/kbd_kc_pkg.sv]
// Shared types, codes and helpers for the keyboard keycode controller.
`default_nettype none

package kbd_kc_pkg;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_LINE    = 2'd2;

  localparam logic [1:0] MODE_SELFTEST = 2'd0;
  localparam logic [1:0] MODE_STRM_ON  = 2'd1;
  localparam logic [1:0] MODE_STRM_OFF = 2'd2;
  localparam logic [1:0] MODE_SEND     = 2'd3;

  localparam logic [7:0] CODE_STRM_ON  = 8'hFD;
  localparam logic [7:0] CODE_STRM_OFF = 8'hFE;

  localparam logic [6:0] KEY_CTRL       = 7'h63;
  localparam logic [6:0] KEY_LEFT_META  = 7'h66;
  localparam logic [6:0] KEY_RIGHT_META = 7'h67;

  localparam int         TS_W          = 48;
  localparam int         THR_W         = 10;
  localparam logic [9:0] THR_RESET     = 10'd28;
  localparam int         NUM_KEYS      = 128;

  typedef struct packed {
    logic [1:0]      operation;
    logic [6:0]      key_code;
    logic            line_level;
    logic [TS_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic       code_valid;
    logic [7:0] code_byte;
    logic       handshake_seen;
    logic       reset_combo;
    logic       awaiting_handshake;
    logic [1:0] mode;
  } out_item_t;

  // Line encoding: rotate left one bit, then invert.
  function automatic logic [7:0] encode_byte(input logic [7:0] c);
    return ~{c[6:0], c[7]};
  endfunction

endpackage

`default_nettype wire

[rtl/kbd_kc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kbd_kc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/keyboard_keycode_fifo_handshake.sv]
// Keyboard controller top level: key map, type-ahead FIFO, handshake and mode logic.
//
// Input channel (in_valid / in_stall / in_data): one event per request, a key
// press, a key release, or a serial line level change with its timestamp.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// accepted request: the byte sent (if any), handshake and reset-combo flags,
// and the waiting flag and mode after the event.
// cfg_write_en / cfg_write_data set the minimum handshake pulse length; write
// it only while no request is in flight.
// One request per cycle while in_stall is low; its result is registered into
// the output register or, if that is held, the skid register. All state (key
// map, FIFO pointers, edge times, mode) updates at the accepting edge, so the
// next request sees it at once. The FIFO head comes from a registered RAM
// addressed by the next head pointer, with a one-entry write bypass.
// Reset: clear the key map, empty the FIFO, enter self-test with the waiting
// flag set, zero both edge times and load a threshold of 28 timestamp units.
// Stall: a result that meets a held output register goes into a skid register;
// while that is full, in_stall is raised and no new request is taken.
`default_nettype none

module keyboard_keycode_fifo_handshake #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire kbd_kc_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output kbd_kc_pkg::out_item_t      out_data,
  input  wire logic                  cfg_write_en,
  input  wire logic [9:0]            cfg_write_data
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 1;

  // Architectural state
  logic [kbd_kc_pkg::NUM_KEYS-1:0]  key_map, key_map_next;
  logic [AW-1:0]                    head, head_next;
  logic [CW-1:0]                    count, count_next;
  logic [1:0]                       mode, mode_next;
  logic                             waiting, waiting_next;
  logic [kbd_kc_pkg::TS_W-1:0]      low_time, low_time_next;
  logic [kbd_kc_pkg::TS_W-1:0]      high_time, high_time_next;
  logic [kbd_kc_pkg::THR_W-1:0]     threshold;

  // FIFO head bypass
  logic                             byp_valid;
  logic [7:0]                       byp_data;
  logic [7:0]                       ram_rdata;
  logic [7:0]                       head_data;

  // Output register and skid stage
  kbd_kc_pkg::out_item_t            result, skid_data;
  logic                             skid_valid;

  // Step logic
  logic                             accept;
  logic                             full;
  logic                             enq, pop;
  logic [7:0]                       enq_code, pop_code;
  logic [AW-1:0]                    tail, head_inc;
  logic [SW-1:0]                    tail_sum;
  logic                             send;
  logic [7:0]                       send_code;
  logic                             hs, combo;
  logic [kbd_kc_pkg::TS_W:0]        diff;
  logic [kbd_kc_pkg::THR_W-1:0]     thr_eff;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign full     = (count >= CW'(FIFO_DEPTH));

  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(FIFO_DEPTH)) ? AW'(tail_sum - SW'(FIFO_DEPTH))
                                                   : AW'(tail_sum);
  assign head_inc = (head == AW'(FIFO_DEPTH - 1)) ? '0 : head + AW'(1);

  // Bypass the RAM when the entry just written is the one being read.
  assign head_data = byp_valid ? byp_data : ram_rdata;

  // A zero threshold behaves as one.
  assign thr_eff = (threshold == '0) ? kbd_kc_pkg::THR_W'(1) : threshold;
  assign diff    = {1'b0, high_time_next} - {1'b0, low_time_next};

  always_comb begin
    key_map_next   = key_map;
    mode_next      = mode;
    waiting_next   = waiting;
    low_time_next  = low_time;
    high_time_next = high_time;
    enq            = 1'b0;
    enq_code       = 8'h00;
    pop            = 1'b0;
    pop_code       = 8'h00;
    send           = 1'b0;
    send_code      = 8'h00;
    hs             = 1'b0;
    combo          = 1'b0;

    if (accept) begin
      case (in_data.operation)
        kbd_kc_pkg::OP_PRESS: begin
          if (!key_map[in_data.key_code] && !full) begin
            key_map_next[in_data.key_code] = 1'b1;
            enq      = 1'b1;
            enq_code = {1'b0, in_data.key_code};
            combo    = key_map_next[kbd_kc_pkg::KEY_CTRL] &&
                       key_map_next[kbd_kc_pkg::KEY_LEFT_META] &&
                       key_map_next[kbd_kc_pkg::KEY_RIGHT_META];
          end
        end
        kbd_kc_pkg::OP_RELEASE: begin
          if (key_map[in_data.key_code] && !full) begin
            key_map_next[in_data.key_code] = 1'b0;
            enq      = 1'b1;
            enq_code = {1'b1, in_data.key_code};
          end
        end
        kbd_kc_pkg::OP_LINE: begin
          // Record an edge only when it starts a new phase of the pulse.
          if (in_data.line_level) begin
            if (high_time <= low_time) high_time_next = in_data.timestamp;
          end else begin
            if (low_time <= high_time) low_time_next = in_data.timestamp;
          end
          hs = !diff[kbd_kc_pkg::TS_W] &&
               (diff[kbd_kc_pkg::TS_W-1:0] >= kbd_kc_pkg::TS_W'(thr_eff));
          if (hs) begin
            case (mode)
              kbd_kc_pkg::MODE_SELFTEST: begin
                mode_next = kbd_kc_pkg::MODE_STRM_ON;
                send      = 1'b1;
                send_code = kbd_kc_pkg::CODE_STRM_ON;
              end
              kbd_kc_pkg::MODE_STRM_ON: begin
                mode_next = kbd_kc_pkg::MODE_STRM_OFF;
                send      = 1'b1;
                send_code = kbd_kc_pkg::CODE_STRM_OFF;
              end
              default: begin
                mode_next = kbd_kc_pkg::MODE_SEND;
                if (count != '0) begin
                  pop       = 1'b1;
                  pop_code  = head_data;
                  send      = 1'b1;
                  send_code = head_data;
                end else begin
                  waiting_next = 1'b0;
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase

      // Idle link: a new code goes straight out in send mode.
      if (enq && !waiting) begin
        mode_next = kbd_kc_pkg::MODE_SEND;
        pop       = 1'b1;
        pop_code  = (count == '0) ? enq_code : head_data;
        send      = 1'b1;
        send_code = pop_code;
      end

      if (send) begin
        waiting_next = 1'b1;
      end
    end

    head_next = pop ? head_inc : head;
    case ({enq, pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_comb begin
    result.code_valid         = send;
    result.code_byte          = send ? kbd_kc_pkg::encode_byte(send_code) : 8'h00;
    result.handshake_seen     = hs;
    result.reset_combo        = combo;
    result.awaiting_handshake = waiting_next;
    result.mode               = mode_next;
  end

  kbd_kc_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (enq),
    .waddr (tail),
    .wdata (enq_code),
    .raddr (head_next),
    .rdata (ram_rdata)
  );

  // Hold architectural state; advance on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_map   <= '0;
      head      <= '0;
      count     <= '0;
      mode      <= kbd_kc_pkg::MODE_SELFTEST;
      waiting   <= 1'b1;
      low_time  <= '0;
      high_time <= '0;
      threshold <= kbd_kc_pkg::THR_RESET;
      byp_valid <= 1'b0;
    end else begin
      key_map   <= key_map_next;
      head      <= head_next;
      count     <= count_next;
      mode      <= mode_next;
      waiting   <= waiting_next;
      low_time  <= low_time_next;
      high_time <= high_time_next;
      byp_valid <= enq && (tail == head_next);
      if (cfg_write_en) begin
        threshold <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      byp_data <= enq_code;
    end
  end

  // Output register with skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/kbd_kc_checker.sv]
// Port-level checker for the keyboard keycode controller, bound to the top level.
`default_nettype none

module kbd_kc_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire kbd_kc_pkg::in_item_t  in_data,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire kbd_kc_pkg::out_item_t out_data
);

  // Stalled request holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset drops any pending result.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // Every sent byte leaves the controller awaiting a handshake.
  a_send_waits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.code_valid |-> out_data.awaiting_handshake)
    else $error("byte sent without waiting flag");

  // A byte sent without a handshake comes from the queue in send mode.
  a_send_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.code_valid && !out_data.handshake_seen
      |-> out_data.mode == kbd_kc_pkg::MODE_SEND)
    else $error("unsolicited byte outside send mode");

endmodule

bind keyboard_keycode_fifo_handshake kbd_kc_checker u_kbd_kc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[dv/tb_keyboard_keycode_fifo_handshake.sv]
// Self-checking testbench for the keyboard keycode FIFO and serial handshake controller.
`timescale 1ns / 1ps

module tb_keyboard_keycode_fifo_handshake;
  import kbd_kc_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;     // cycles without any request moving
  localparam int PHASE_ITEMS = 325;
  localparam int LONG_HOLD = 80;        // receiver hold-off that backs up the block
  localparam logic [1:0] OP_NOP = 2'd3; // no-op event: state untouched

  // Result of a request that changes nothing while self-test waits.
  localparam out_item_t QUIET_RES = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, MODE_SELFTEST};

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_write_en = 1'b0;
  logic [9:0] cfg_write_data = '0;

  always #5 clk = ~clk;

  keyboard_keycode_fifo_handshake #(.FIFO_DEPTH(FIFO_DEPTH)) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // ---------------------------------------------------------------------------
  // Controller mirror: key map, type-ahead queue, mode, waiting flag, edge times
  // ---------------------------------------------------------------------------
  logic [NUM_KEYS-1:0] keys_down = '0;
  logic [7:0]          type_ahead [$];
  logic [1:0]          ctl_mode = MODE_SELFTEST;
  logic                awaiting = 1'b1;
  logic [TS_W-1:0]     low_mark = '0;
  logic [TS_W-1:0]     high_mark = '0;
  logic [THR_W-1:0]    pulse_min = THR_RESET;
  out_item_t           step_res;

  out_item_t           expected_results [$];
  int                  errors = 0;

  // Put a byte on the line: rotate left by one, invert, then wait for a handshake.
  function automatic void send_code(logic [7:0] c);
    step_res.code_valid = 1'b1;
    step_res.code_byte  = ~((c << 1) | (c >> 7));
    awaiting = 1'b1;
  endfunction

  // Act on the current mode: announce stream on/off, or pop the queue head in send.
  function automatic void serve_mode();
    case (ctl_mode)
      MODE_STRM_ON:  send_code(CODE_STRM_ON);
      MODE_STRM_OFF: send_code(CODE_STRM_OFF);
      MODE_SEND: begin
        if (type_ahead.size() != 0) send_code(type_ahead.pop_front());
        else awaiting = 1'b0;
      end
      default: awaiting = 1'b1;
    endcase
  endfunction

  // Append a code; if the line is free, switch to send and transmit right away.
  function automatic void queue_code(logic [7:0] c);
    type_ahead.push_back(c);
    if (!awaiting) begin
      ctl_mode = MODE_SEND;
      serve_mode();
    end
  endfunction

  function automatic out_item_t predict_event(in_item_t ev);
    logic [TS_W-1:0] need;
    step_res = '0;
    case (ev.operation)
      OP_PRESS: begin
        if (!keys_down[ev.key_code] && type_ahead.size() < FIFO_DEPTH) begin
          keys_down[ev.key_code] = 1'b1;
          queue_code({1'b0, ev.key_code});
          step_res.reset_combo = keys_down[KEY_CTRL] && keys_down[KEY_LEFT_META] &&
                                 keys_down[KEY_RIGHT_META];
        end
      end
      OP_RELEASE: begin
        if (keys_down[ev.key_code] && type_ahead.size() < FIFO_DEPTH) begin
          keys_down[ev.key_code] = 1'b0;
          queue_code({1'b1, ev.key_code});
        end
      end
      OP_LINE: begin
        // Record an edge only when it opens a new half of the pulse.
        if (ev.line_level) begin
          if (high_mark <= low_mark) high_mark = ev.timestamp;
        end else if (low_mark <= high_mark) begin
          low_mark = ev.timestamp;
        end
        need = (pulse_min == 0) ? 1 : pulse_min;
        if (high_mark > low_mark && high_mark - low_mark >= need) begin
          step_res.handshake_seen = 1'b1;
          case (ctl_mode)
            MODE_SELFTEST: ctl_mode = MODE_STRM_ON;
            MODE_STRM_ON:  ctl_mode = MODE_STRM_OFF;
            default:       ctl_mode = MODE_SEND;
          endcase
          serve_mode();
        end
      end
      default: ;
    endcase
    step_res.awaiting_handshake = awaiting;
    step_res.mode = ctl_mode;
    return step_res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  int              burst_left = 0;
  logic            line_high = 1'b0;
  logic [TS_W-1:0] line_clock = '0;
  stim_row_t       directed_rows [$];

  // Hold the request until taken, record its expectation, then pace the next one.
  task automatic offer(input in_item_t ev, input bit typed, input out_item_t typed_res);
    out_item_t res;
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
    res = predict_event(ev);
    expected_results.push_back(typed ? typed_res : res);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Mostly short bursts, now and then a long run with no gaps at all.
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Drop valid and wait until every result is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pulse_min = v;
  endtask

  function automatic void add_row(logic [1:0] op, logic [6:0] key, logic lvl,
                                  logic [TS_W-1:0] ts, bit typed, out_item_t res);
    stim_row_t r;
    r.ev.operation  = op;
    r.ev.key_code   = key;
    r.ev.line_level = lvl;
    r.ev.timestamp  = ts;
    r.typed = typed;
    r.res   = res;
    directed_rows.push_back(r);
  endfunction

  task automatic run_random_phase(input logic [THR_W-1:0] thr, input int n);
    in_item_t        ev;
    logic [63:0]     wide;
    logic [TS_W-1:0] min_len;
    logic [TS_W-1:0] span;
    logic [6:0]      kc;
    int              pick;
    set_threshold(thr);
    min_len = (thr == 0) ? 1 : thr;
    // Jump the line clock ahead so the upper timestamp bits move too.
    line_clock += {14'($urandom_range(0, 16383)), 32'($urandom)};
    repeat (n) begin
      wide = {$urandom, $urandom};
      ev.timestamp  = wide[TS_W-1:0];
      ev.key_code   = 7'($urandom_range(0, 127));
      ev.line_level = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Key event: favor the reset-combo keys and a small pool, mostly
        // pressing keys that are up and releasing keys that are down.
        case ($urandom_range(0, 5))
          0: kc = KEY_CTRL;
          1: kc = KEY_LEFT_META;
          2: kc = KEY_RIGHT_META;
          3, 4: kc = 7'($urandom_range(0, 15));
          default: kc = 7'($urandom_range(0, 127));
        endcase
        ev.key_code  = kc;
        ev.operation = (keys_down[kc] ^ ($urandom_range(0, 99) < 15)) ? OP_RELEASE
                                                                        : OP_PRESS;
      end else if (pick < 85) begin
        // Well-formed line toggle; low pulses sit around the threshold.
        ev.operation = OP_LINE;
        if (line_high) begin
          span = $urandom_range(1, 20);
        end else begin
          case ($urandom_range(0, 4))
            0, 1, 2: span = min_len + $urandom_range(0, 3);
            3:       span = min_len - 1;
            default: span = min_len + $urandom_range(0, 300);
          endcase
        end
        line_high = !line_high;
        line_clock += span;
        ev.line_level = line_high;
        ev.timestamp  = line_clock;
      end else if (pick < 93) begin
        ev.operation = OP_NOP;
      end else begin
        // Repeated edge at the current level: may accept the same pulse again.
        ev.operation = OP_LINE;
        ev.line_level = line_high;
        line_clock += $urandom_range(0, 30);
        ev.timestamp = line_clock;
      end
      offer(ev, 1'b0, '0);
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table: no-op with all fields at max, reset combo, redundant
    // press and release, fill the queue while self-test waits, full-queue drops,
    // then a pulse one short of the threshold and one exactly at it.
    add_row(OP_NOP, 7'd127, 1'b1, '1, 1'b1, QUIET_RES);
    add_row(OP_PRESS, KEY_CTRL, 1'b0, 48'h0, 1'b0, '0);
    add_row(OP_PRESS, KEY_LEFT_META, 1'b1, 48'h5555_5555_5555, 1'b0, '0);
    add_row(OP_PRESS, KEY_RIGHT_META, 1'b0, 48'hAAAA_AAAA_AAAA, 1'b1,
            '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, MODE_SELFTEST});
    add_row(OP_PRESS, KEY_CTRL, 1'b1, 48'h0, 1'b1, QUIET_RES);
    add_row(OP_RELEASE, 7'd5, 1'b0, 48'h0, 1'b1, QUIET_RES);
    add_row(OP_PRESS, 7'd127, 1'b1, 48'h0, 1'b0, '0);
    add_row(OP_RELEASE, 7'd127, 1'b0, 48'h0, 1'b0, '0);
    for (int k = 0; k <= 10; k++)
      add_row(OP_PRESS, 7'(k), 1'(k), 48'hA5A5_5A5A_0000 + k, 1'b0, '0);
    add_row(OP_PRESS, 7'd11, 1'b0, 48'h0, 1'b1, QUIET_RES);
    add_row(OP_RELEASE, 7'd0, 1'b0, 48'h0, 1'b1, QUIET_RES);
    add_row(OP_LINE, 7'd0, 1'b0, 48'd100, 1'b0, '0);
    add_row(OP_LINE, 7'd0, 1'b1, 48'd127, 1'b0, '0);
    add_row(OP_LINE, 7'd0, 1'b0, 48'd200, 1'b0, '0);
    add_row(OP_LINE, 7'd0, 1'b1, 48'd228, 1'b1,
            '{1'b1, 8'h04, 1'b1, 1'b0, 1'b1, MODE_STRM_ON});
    foreach (directed_rows[i])
      offer(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].res);
    settle();
    line_high  = 1'b1;
    line_clock = 48'd228;

    // Random phases across threshold extremes, zero, a random middle value and the reset value.
    run_random_phase(10'd1023, PHASE_ITEMS);
    run_random_phase(10'd1, PHASE_ITEMS);
    run_random_phase(10'd0, PHASE_ITEMS);
    run_random_phase(10'($urandom_range(2, 1022)), PHASE_ITEMS);
    run_random_phase(THR_RESET, PHASE_ITEMS);

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("results still outstanding: %0d", expected_results.size());
      errors++;
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern of its own plus two long hold-offs
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int pattern_left = 0;
  int hold_left = 0;
  int delivered = 0;
  bit first_hold_done = 1'b0;
  bit second_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) delivered++;
      if (delivered >= 150 && !first_hold_done) begin
        first_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end else if (delivered >= 900 && !second_hold_done) begin
        second_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2:    stall_pct = 20;
            3:    stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pattern_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  out_item_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: %p", out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.code_valid !== want.code_valid) begin
          $error("code_valid: expected %0d, got %0d", want.code_valid, out_data.code_valid);
          errors++;
        end
        if (out_data.code_byte !== want.code_byte) begin
          $error("code_byte: expected %02h, got %02h", want.code_byte, out_data.code_byte);
          errors++;
        end
        if (out_data.handshake_seen !== want.handshake_seen) begin
          $error("handshake_seen: expected %0d, got %0d",
                 want.handshake_seen, out_data.handshake_seen);
          errors++;
        end
        if (out_data.reset_combo !== want.reset_combo) begin
          $error("reset_combo: expected %0d, got %0d", want.reset_combo, out_data.reset_combo);
          errors++;
        end
        if (out_data.awaiting_handshake !== want.awaiting_handshake) begin
          $error("awaiting_handshake: expected %0d, got %0d",
                 want.awaiting_handshake, out_data.awaiting_handshake);
          errors++;
        end
        if (out_data.mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, out_data.mode);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no request moves on either side for too long.
  int idle = 0;

  initial begin
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
rtl/kbd_kc_pkg.sv
rtl/kbd_kc_ram.sv
rtl/keyboard_keycode_fifo_handshake.sv
rtl/kbd_kc_checker.sv
dv/tb_keyboard_keycode_fifo_handshake.sv
